// File: design/assert_macros.svh
// Assertion macros used by the decision tree core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is asserted.
`define DTLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds across reset.
`define DTLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dtle_pkg.sv
// Types and constants shared by the decision tree load and evaluate core.
package dtle_pkg;

  // Fixed field and register widths.
  localparam int TREE_WORD_W    = 32;
  localparam int INPUT_BITS_W   = 64;
  localparam int IN_WIDTH_W     = 7;
  localparam int NODE_COUNT_W   = 10;
  localparam int CFG_DATA_W     = 10;
  localparam int NODE_ENTRY_W   = 7;
  localparam int MAX_INPUT_BITS = 64;

  // Reset values of the configuration registers.
  localparam logic [IN_WIDTH_W-1:0]   IN_WIDTH_RST   = 7'd64;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 10'd1;

  // Configuration register indexes.
  localparam logic CFG_INPUT_WIDTH = 1'b0;
  localparam logic CFG_NODE_COUNT  = 1'b1;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_EVAL    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [TREE_WORD_W-1:0]  tree_word;
    logic [INPUT_BITS_W-1:0] input_bits;
  } in_word_t;

  typedef struct packed {
    status_e status;
    logic    answer;
  } out_word_t;

  // Controls for the node store and right-link memories.
  typedef struct packed {
    logic node_we;
    logic link_we;
    logic rd_en;
  } node_mem_ctl_t;

  // Controls for the pending-node stack.
  typedef struct packed {
    logic push;
    logic rd_en;
  } stack_ctl_t;

endpackage

// File: design/dtle_node_mem.sv
// Node store and right-link memories with one write and one registered read port each.
module dtle_node_mem #(
  parameter int DEPTH = 1023,
  parameter int AW    = 10,
  parameter int PW    = 10
) (
  input  logic                          clk,
  input  dtle_pkg::node_mem_ctl_t       ctl,
  input  logic [AW-1:0]                 node_waddr,
  input  logic [dtle_pkg::NODE_ENTRY_W-1:0] node_wdata,
  input  logic [AW-1:0]                 link_waddr,
  input  logic [PW-1:0]                 link_wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [dtle_pkg::NODE_ENTRY_W-1:0] node_rdata,
  output logic [PW-1:0]                 link_rdata
);
  import dtle_pkg::*;

  logic [NODE_ENTRY_W-1:0] node_store [DEPTH];
  logic [PW-1:0]           right_link [DEPTH];

  // Write ports.
  always_ff @(posedge clk) begin
    if (ctl.node_we) begin
      node_store[node_waddr] <= node_wdata;
    end
    if (ctl.link_we) begin
      right_link[link_waddr] <= link_wdata;
    end
  end

  // Registered read of both memories at the same node.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      node_rdata <= node_store[raddr];
      link_rdata <= right_link[raddr];
    end
  end

endmodule

// File: design/dtle_stack.sv
// Pending-node stack memory holding node index and depth of open internal nodes.
module dtle_stack #(
  parameter int DEPTH = 16,
  parameter int SAW   = 4,
  parameter int AW    = 10,
  parameter int DW    = 5
) (
  input  logic                   clk,
  input  dtle_pkg::stack_ctl_t   ctl,
  input  logic [SAW-1:0]         waddr,
  input  logic [AW-1:0]          wnode,
  input  logic [DW-1:0]          wdepth,
  input  logic [SAW-1:0]         raddr,
  output logic [AW-1:0]          rnode,
  output logic [DW-1:0]          rdepth
);
  import dtle_pkg::*;

  logic [AW-1:0] node_mem  [DEPTH];
  logic [DW-1:0] depth_mem [DEPTH];

  // Push writes one entry.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      node_mem[waddr]  <= wnode;
      depth_mem[waddr] <= wdepth;
    end
  end

  // Registered read of the top entry.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rnode  <= node_mem[raddr];
      rdepth <= depth_mem[raddr];
    end
  end

endmodule

// File: design/decision_tree_load_and_evaluate_core.sv
// Top level of the decision tree core: sequencer, load checks and tree walk.
//
// The core takes one word at a time and answers each with one result word. Restart,
// unused commands, evaluate before the tree is ready and every load but a closing leaf
// load pass through the execute and done states. A leaf load that closes a pending
// internal node also passes through the pop state, since it reads the pending-node stack.
// An evaluate walks from the root towards a leaf, visiting at most TREE_DEPTH + 1
// nodes: the walk makes one read of the node memory per level through a single read
// port. No new word is taken until the previous result has been handed to the output
// register, so the next word can be accepted in the cycle after that; while the output
// is stalled the core waits in its done state. The output register holds its result
// while the next word is taken. Configuration is written through a plain write port
// and must only change while the core is idle.
`include "assert_macros.svh"

module decision_tree_load_and_evaluate_core #(
  parameter int MAX_NODES  = 1023,
  parameter int TREE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dtle_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dtle_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [dtle_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dtle_pkg::*;

  localparam int PW  = $clog2(MAX_NODES + 1);
  localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int XW  = (PW > NODE_COUNT_W) ? PW : NODE_COUNT_W;
  localparam int DW  = $clog2(TREE_DEPTH + 1);
  localparam int SAW = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POP  = 5'b00100,
    S_EVAL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                  state, state_next;
  cmd_e                    cmd_q;
  logic [TREE_WORD_W-1:0]  word_q;
  logic [INPUT_BITS_W-1:0] bits_q;
  logic [IN_WIDTH_W-1:0]   input_width;
  logic [NODE_COUNT_W-1:0] node_count;
  logic [DW-1:0]           stack_level, stack_level_next;
  logic [PW-1:0]           write_position, write_position_next;
  logic [DW-1:0]           current_depth, current_depth_next;
  logic                    tree_ready, tree_ready_next;
  logic                    load_failed, load_failed_next;
  logic [PW-1:0]           eval_node, eval_node_next;
  logic [DW-1:0]           eval_steps, eval_steps_next;
  status_e                 res_status, res_status_next;
  logic                    res_answer, res_answer_next;

  // Memory interfaces.
  node_mem_ctl_t           mem_ctl;
  logic [AW-1:0]           mem_raddr;
  logic [NODE_ENTRY_W-1:0] node_wdata;
  logic [NODE_ENTRY_W-1:0] node_rdata;
  logic [AW-1:0]           link_waddr;
  logic [PW-1:0]           link_rdata;
  stack_ctl_t              stk_ctl;
  logic [AW-1:0]           stk_rnode;
  logic [DW-1:0]           stk_rdepth;

  // Configuration limits, load checks and walk step signals.
  logic [IN_WIDTH_W-1:0]   w_eff;
  logic [IN_WIDTH_W-1:0]   depth_limit;
  logic                    pos_bad;
  logic                    leaf_bad;
  logic                    internal_bad;
  logic                    take_bit;
  logic [PW-1:0]           walk_next;
  logic                    out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Effective input width and depth limit from configuration.
  assign w_eff = (input_width > IN_WIDTH_W'(MAX_INPUT_BITS)) ?
                 IN_WIDTH_W'(MAX_INPUT_BITS) : input_width;
  assign depth_limit = (w_eff < IN_WIDTH_W'(TREE_DEPTH)) ? w_eff : IN_WIDTH_W'(TREE_DEPTH);

  // Load checks on the latched word.
  assign pos_bad = (XW'(write_position) >= XW'(node_count)) ||
                   (write_position >= PW'(MAX_NODES));
  assign leaf_bad = |word_q[TREE_WORD_W-2:1];
  assign internal_bad = (word_q >= TREE_WORD_W'(w_eff)) ||
                        ((8'(current_depth) + 8'd1) > 8'(depth_limit)) ||
                        (stack_level >= DW'(TREE_DEPTH));

  // Walk step: go right on a set input bit, otherwise to the next node.
  assign take_bit  = bits_q[node_rdata[5:0]];
  assign walk_next = take_bit ? link_rdata : (eval_node + PW'(1));

  // Node write data: leaf flag with answer bit, or tested bit index.
  assign node_wdata = word_q[TREE_WORD_W-1] ? {1'b1, 5'b0, word_q[0]} : {1'b0, word_q[5:0]};
  assign link_waddr = stk_rnode;

  // Sequencer.
  always_comb begin
    state_next          = state;
    stack_level_next    = stack_level;
    write_position_next = write_position;
    current_depth_next  = current_depth;
    tree_ready_next     = tree_ready;
    load_failed_next    = load_failed;
    eval_node_next      = eval_node;
    eval_steps_next     = eval_steps;
    res_status_next     = res_status;
    res_answer_next     = res_answer;
    mem_ctl             = '0;
    mem_raddr           = '0;
    stk_ctl             = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next      = S_DONE;
        res_status_next = ST_OK;
        res_answer_next = 1'b0;
        case (cmd_q)
          CMD_RESTART: begin
            stack_level_next    = '0;
            write_position_next = '0;
            current_depth_next  = '0;
            tree_ready_next     = 1'b0;
            load_failed_next    = 1'b0;
          end
          CMD_LOAD: begin
            if (load_failed || tree_ready || pos_bad ||
                (word_q[TREE_WORD_W-1] && leaf_bad) ||
                (!word_q[TREE_WORD_W-1] && internal_bad)) begin
              load_failed_next = 1'b1;
              tree_ready_next  = 1'b0;
              res_status_next  = ST_MALFORMED;
            end else if (word_q[TREE_WORD_W-1]) begin
              mem_ctl.node_we     = 1'b1;
              write_position_next = write_position + PW'(1);
              if (stack_level == '0) begin
                if ((XW'(write_position) + XW'(1)) != XW'(node_count)) begin
                  load_failed_next = 1'b1;
                  tree_ready_next  = 1'b0;
                  res_status_next  = ST_MALFORMED;
                end else begin
                  tree_ready_next = 1'b1;
                  res_status_next = ST_COMPLETE;
                end
              end else begin
                stk_ctl.rd_en = 1'b1;
                state_next    = S_POP;
              end
            end else begin
              mem_ctl.node_we     = 1'b1;
              stk_ctl.push        = 1'b1;
              write_position_next = write_position + PW'(1);
              current_depth_next  = current_depth + DW'(1);
              stack_level_next    = stack_level + DW'(1);
            end
          end
          CMD_EVAL: begin
            if (tree_ready) begin
              mem_ctl.rd_en   = 1'b1;
              mem_raddr       = '0;
              eval_node_next  = '0;
              eval_steps_next = '0;
              state_next      = S_EVAL;
            end else begin
              res_status_next = load_failed ? ST_MALFORMED : ST_NOT_READY;
            end
          end
          default: begin
            res_status_next = ST_NOT_READY;
          end
        endcase
      end
      S_POP: begin
        // Close the pending internal node: its right child starts here.
        mem_ctl.link_we    = 1'b1;
        current_depth_next = stk_rdepth + DW'(1);
        stack_level_next   = stack_level - DW'(1);
        res_status_next    = ST_OK;
        state_next         = S_DONE;
      end
      S_EVAL: begin
        if (node_rdata[NODE_ENTRY_W-1]) begin
          res_answer_next = node_rdata[0];
          state_next      = S_DONE;
        end else if ((eval_steps == DW'(TREE_DEPTH)) || (walk_next >= PW'(MAX_NODES))) begin
          res_answer_next = 1'b0;
          state_next      = S_DONE;
        end else begin
          mem_ctl.rd_en   = 1'b1;
          mem_raddr       = AW'(walk_next);
          eval_node_next  = walk_next;
          eval_steps_next = eval_steps + DW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stack_level    <= '0;
      write_position <= '0;
      current_depth  <= '0;
      tree_ready     <= 1'b0;
      load_failed    <= 1'b0;
      input_width    <= IN_WIDTH_RST;
      node_count     <= NODE_COUNT_RST;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      stack_level    <= stack_level_next;
      write_position <= write_position_next;
      current_depth  <= current_depth_next;
      tree_ready     <= tree_ready_next;
      load_failed    <= load_failed_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_WIDTH: input_width <= cfg_data[IN_WIDTH_W-1:0];
          CFG_NODE_COUNT:  node_count  <= cfg_data[NODE_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: latched input word, walk position and result.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q  <= in_data.cmd;
      word_q <= in_data.tree_word;
      bits_q <= in_data.input_bits;
    end
    eval_node  <= eval_node_next;
    eval_steps <= eval_steps_next;
    res_status <= res_status_next;
    res_answer <= res_answer_next;
    if (state == S_DONE && out_free) begin
      out_data.status <= res_status;
      out_data.answer <= res_answer;
    end
  end

  dtle_node_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW),
    .PW    (PW)
  ) u_node_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .node_waddr (AW'(write_position)),
    .node_wdata (node_wdata),
    .link_waddr (link_waddr),
    .link_wdata (write_position),
    .raddr      (mem_raddr),
    .node_rdata (node_rdata),
    .link_rdata (link_rdata)
  );

  dtle_stack #(
    .DEPTH (TREE_DEPTH),
    .SAW   (SAW),
    .AW    (AW),
    .DW    (DW)
  ) u_stack (
    .clk    (clk),
    .ctl    (stk_ctl),
    .waddr  (SAW'(stack_level)),
    .wnode  (AW'(write_position)),
    .wdepth (current_depth),
    .raddr  (SAW'(stack_level - DW'(1))),
    .rnode  (stk_rnode),
    .rdepth (stk_rdepth)
  );

  // Checks on the sequencer and load bookkeeping.
  `DTLE_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE) && !out_valid, "reset did not idle the core")
  `DTLE_ASSERT(a_accept_exec, (in_valid && !in_stall) |=> (state == S_EXEC), "accepted word not executed")
  `DTLE_ASSERT(a_ready_not_failed, tree_ready |-> !load_failed, "tree ready and failed together")
  `DTLE_ASSERT(a_ready_stack_empty, tree_ready |-> (stack_level == '0), "ready tree has open nodes")
  `DTLE_ASSERT(a_level_in_depth, stack_level <= current_depth, "stack deeper than current depth")
  `DTLE_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state == S_DONE), "result without completion")

endmodule
